### rtl/core/rbpj_pkg.sv
package rbpj_pkg;

  localparam int CW  = 33;
  localparam int SW  = 66;
  localparam int RW  = 33;
  localparam int HW  = 16;
  localparam int LAT = 53;

  localparam logic [31:0] ATAN_TURNS32 [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

### rtl/core/rbpj_delay.sv
module rbpj_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

### rtl/core/rbpj_isqrt.sv
module rbpj_isqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [rbpj_pkg::SW-1:0] s,
  output logic [rbpj_pkg::RW-1:0] root
);
  import rbpj_pkg::*;

  localparam int RMW = SW + 1;

  logic [RMW-1:0] rem_r  [1:RW];
  logic [RW-1:0]  root_r [1:RW];
  logic [RMW-1:0] rem_in [0:RW-1];
  logic [RW-1:0]  root_in[0:RW-1];

  for (genvar j = 0; j < RW; j++) begin : g_bit
    localparam int B = RW - 1 - j;
    logic [RMW-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in[j]  = RMW'(s);
      assign root_in[j] = '0;
    end else begin : g_next
      assign rem_in[j]  = rem_r[j];
      assign root_in[j] = root_r[j];
    end

    assign trial = (RMW'(root_in[j]) << (B + 1)) + (RMW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in[j] >= trial) begin
          rem_r[j+1]  <= rem_in[j] - trial;
          root_r[j+1] <= root_in[j] | (RW'(1) << B);
        end else begin
          rem_r[j+1]  <= rem_in[j];
          root_r[j+1] <= root_in[j];
        end
      end
    end
  end

  assign root = root_r[RW];

endmodule

### rtl/core/rbpj_div.sv
module rbpj_div #(
  parameter int DW = 33,
  parameter int QB = 15
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB:0]   quo
);

  logic [DW-1:0] rem_r [0:QB];
  logic [DW-1:0] den_r [0:QB];
  logic [QB:0]   q_r   [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      if (num >= den) begin
        rem_r[0] <= num - den;
        q_r[0]   <= (QB+1)'(1) << QB;
      end else begin
        rem_r[0] <= num;
        q_r[0]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_bit
    localparam int B = QB - 1 - j;
    logic [DW:0] sh;
    logic [DW:0] dext;

    assign sh   = {rem_r[j], 1'b0};
    assign dext = {1'b0, den_r[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j+1] <= den_r[j];
        if (sh >= dext) begin
          rem_r[j+1] <= DW'(sh - dext);
          q_r[j+1]   <= q_r[j] | ((QB+1)'(1) << B);
        end else begin
          rem_r[j+1] <= DW'(sh);
          q_r[j+1]   <= q_r[j];
        end
      end
    end
  end

  assign quo = q_r[QB];

endmodule

### rtl/core/rbpj_cordic.sv
module rbpj_cordic #(
  parameter int STEPS = 16,
  parameter int ABITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [rbpj_pkg::CW-1:0] x,
  input  logic signed [rbpj_pkg::CW-1:0] y,
  output logic [rbpj_pkg::HW-1:0]        angle
);
  import rbpj_pkg::*;

  localparam int XW = CW + 3;

  function automatic logic [ABITS-1:0] atan_step(input int k);
    logic [32:0] s;
    s = {1'b0, ATAN_TURNS32[k]} + (33'd1 << (31 - ABITS));
    return s[31:32-ABITS];
  endfunction

  logic signed [XW-1:0] x_r   [0:STEPS];
  logic signed [XW-1:0] y_r   [0:STEPS];
  logic [ABITS-1:0]     acc_r [0:STEPS];
  logic signed [XW-1:0] xe;
  logic signed [XW-1:0] ye;

  assign xe = {{(XW-CW){x[CW-1]}}, x};
  assign ye = {{(XW-CW){y[CW-1]}}, y};

  always_ff @(posedge clk) begin
    if (en) begin
      if (x[CW-1]) begin
        x_r[0]   <= -xe;
        y_r[0]   <= -ye;
        acc_r[0] <= ABITS'(1) << (ABITS - 1);
      end else begin
        x_r[0]   <= xe;
        y_r[0]   <= ye;
        acc_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [ABITS-1:0] T = atan_step(i);
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][XW-1]) begin
          x_r[i+1]   <= x_r[i] + ys;
          y_r[i+1]   <= y_r[i] - xs;
          acc_r[i+1] <= acc_r[i] + T;
        end else begin
          x_r[i+1]   <= x_r[i] - ys;
          y_r[i+1]   <= y_r[i] + xs;
          acc_r[i+1] <= acc_r[i] - T;
        end
      end
    end
  end

  if (ABITS > HW) begin : g_round
    localparam int SH = ABITS - HW;
    logic [ABITS-1:0] rnd;
    assign rnd   = acc_r[STEPS] + (ABITS'(1) << (SH - 1));
    assign angle = rnd[ABITS-1:SH];
  end else if (ABITS == HW) begin : g_same
    assign angle = acc_r[STEPS];
  end else begin : g_widen
    assign angle = {acc_r[STEPS], {(HW-ABITS){1'b0}}};
  end

endmodule

### rtl/core/range_bearing_predict_jacobian.sv
// Range, bearing and measurement Jacobian, fully pipelined.
// Throughput: one beat per cycle unless out_stall holds a result beat; depth set by
// the 33-stage square root followed by the 16-stage range divider.
// Reset (rst_n low, synchronous) clears the valid pipeline; data regs keep no reset.
module range_bearing_predict_jacobian #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_landmark_x,
  input  logic signed [31:0] in_landmark_y,
  input  logic signed [31:0] in_robot_x,
  input  logic signed [31:0] in_robot_y,
  input  logic signed [15:0] in_robot_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_predicted_range,
  output logic signed [15:0] out_predicted_bearing,
  output logic signed [15:0] out_jac_range_dx,
  output logic signed [15:0] out_jac_range_dy,
  output logic signed [31:0] out_jac_bearing_dx,
  output logic signed [31:0] out_jac_bearing_dy,
  output logic               out_coincident
);
  import rbpj_pkg::*;

  localparam int CDLY = LAT - 3 - CORDIC_STEPS;
  localparam int FW   = 3 + 1 + HW;

  function automatic logic [15:0] sat16(input logic neg, input logic [15:0] mag);
    logic [15:0] m;
    if (neg) begin
      m = (mag > 16'h8000) ? 16'h8000 : mag;
      return 16'(-m);
    end
    return (mag > 16'h7FFF) ? 16'h7FFF : mag;
  endfunction

  function automatic logic [31:0] sat32(input logic neg, input logic [32:0] mag);
    logic [32:0] m;
    if (neg) begin
      m = (mag > 33'h080000000) ? 33'h080000000 : mag;
      return 32'(-m);
    end
    return (mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
  endfunction

  logic           en;
  logic [LAT-1:0] v_r;

  assign en       = !v_r[LAT-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  // stage 1: differences
  logic signed [CW-1:0] dx_nxt, dy_nxt, dx_r, dy_r;
  logic [CW-1:0]        adx_r, ady_r;
  logic [HW-1:0]        head_r;
  logic                 coin_r;

  assign dx_nxt = {in_landmark_x[31], in_landmark_x} - {in_robot_x[31], in_robot_x};
  assign dy_nxt = {in_landmark_y[31], in_landmark_y} - {in_robot_y[31], in_robot_y};

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      adx_r  <= dx_nxt[CW-1] ? CW'(-dx_nxt) : CW'(dx_nxt);
      ady_r  <= dy_nxt[CW-1] ? CW'(-dy_nxt) : CW'(dy_nxt);
      head_r <= in_robot_heading;
      coin_r <= (dx_nxt == '0) && (dy_nxt == '0);
    end
  end

  // stage 2: partial products, stage 3: sum of squares
  logic [33:0] xhh_r, yhh_r;
  logic [32:0] xhl_r, yhl_r;
  logic [31:0] xll_r, yll_r;
  logic [SW-1:0] s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xhh_r <= 34'(adx_r[32:16]) * 34'(adx_r[32:16]);
      xhl_r <= 33'(adx_r[32:16]) * 33'(adx_r[15:0]);
      xll_r <= 32'(adx_r[15:0]) * 32'(adx_r[15:0]);
      yhh_r <= 34'(ady_r[32:16]) * 34'(ady_r[32:16]);
      yhl_r <= 33'(ady_r[32:16]) * 33'(ady_r[15:0]);
      yll_r <= 32'(ady_r[15:0]) * 32'(ady_r[15:0]);
      s_r   <= (SW'(xhh_r) << 32) + (SW'(xhl_r) << 17) + SW'(xll_r)
             + (SW'(yhh_r) << 32) + (SW'(yhl_r) << 17) + SW'(yll_r);
    end
  end

  logic [2*CW-1:0] abs3, abs36;

  rbpj_delay #(.W(2*CW), .N(2)) u_abs3 (
    .clk(clk), .en(en), .d({adx_r, ady_r}), .q(abs3)
  );
  rbpj_delay #(.W(2*CW), .N(33)) u_abs36 (
    .clk(clk), .en(en), .d(abs3), .q(abs36)
  );

  logic [RW-1:0] r36, r52;

  rbpj_isqrt u_sqrt (.clk(clk), .en(en), .s(s_r), .root(r36));

  logic [32:0] qbx36, qby36, qbx52, qby52;

  rbpj_div #(.DW(64), .QB(32)) u_divbx (
    .clk(clk), .en(en), .num(64'(abs3[2*CW-1:CW])), .den(s_r[63:0]), .quo(qbx36)
  );
  rbpj_div #(.DW(64), .QB(32)) u_divby (
    .clk(clk), .en(en), .num(64'(abs3[CW-1:0])), .den(s_r[63:0]), .quo(qby36)
  );

  logic [15:0] qrx52, qry52;

  rbpj_div #(.DW(RW), .QB(15)) u_divrx (
    .clk(clk), .en(en), .num(abs36[2*CW-1:CW]), .den(r36), .quo(qrx52)
  );
  rbpj_div #(.DW(RW), .QB(15)) u_divry (
    .clk(clk), .en(en), .num(abs36[CW-1:0]), .den(r36), .quo(qry52)
  );

  rbpj_delay #(.W(2*33 + RW), .N(16)) u_q52 (
    .clk(clk), .en(en), .d({qbx36, qby36, r36}), .q({qbx52, qby52, r52})
  );

  logic shi52;

  rbpj_delay #(.W(1), .N(49)) u_shi (
    .clk(clk), .en(en), .d(s_r[SW-1:64] != '0), .q(shi52)
  );

  logic dxneg52, dyneg52, dypos52, coin52;
  logic [HW-1:0] head52;

  rbpj_delay #(.W(FW), .N(51)) u_flags (
    .clk(clk), .en(en),
    .d({dx_r[CW-1], dy_r[CW-1], !dy_r[CW-1] && (dy_r != '0), coin_r, head_r}),
    .q({dxneg52, dyneg52, dypos52, coin52, head52})
  );

  logic [HW-1:0] ang_c, ang52;

  rbpj_cordic #(.STEPS(CORDIC_STEPS), .ABITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .en(en), .x(dx_r), .y(dy_r), .angle(ang_c)
  );
  rbpj_delay #(.W(HW), .N(CDLY)) u_ang (
    .clk(clk), .en(en), .d(ang_c), .q(ang52)
  );

  // output register
  logic [31:0] range_r, range_nxt;
  logic [15:0] bear_r, bear_nxt, jrx_r, jrx_nxt, jry_r, jry_nxt;
  logic [31:0] jbx_r, jbx_nxt, jby_r, jby_nxt;
  logic        coin_out_r;

  always_comb begin
    range_nxt = r52[RW-1] ? 32'hFFFFFFFF : r52[31:0];
    bear_nxt  = (coin52 ? 16'd0 : ang52) - head52;
    jrx_nxt   = sat16(dxneg52, qrx52);
    jry_nxt   = sat16(dyneg52, qry52);
    jbx_nxt   = shi52 ? 32'd0 : sat32(dypos52, qby52);
    jby_nxt   = shi52 ? 32'd0 : sat32(dxneg52, qbx52);
    if (coin52) begin
      range_nxt = '0;
      jrx_nxt   = '0;
      jry_nxt   = '0;
      jbx_nxt   = '0;
      jby_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      range_r    <= range_nxt;
      bear_r     <= bear_nxt;
      jrx_r      <= jrx_nxt;
      jry_r      <= jry_nxt;
      jbx_r      <= jbx_nxt;
      jby_r      <= jby_nxt;
      coin_out_r <= coin52;
    end
  end

  assign out_valid             = v_r[LAT-1];
  assign out_predicted_range   = range_r;
  assign out_predicted_bearing = bear_r;
  assign out_jac_range_dx      = jrx_r;
  assign out_jac_range_dy      = jry_r;
  assign out_jac_bearing_dx    = jbx_r;
  assign out_jac_bearing_dy    = jby_r;
  assign out_coincident        = coin_out_r;

`ifndef NO_ASSERTIONS
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result beat");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted beat did not enter the pipeline");

  a_coin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coincident) |->
      (out_predicted_range == 32'd0 && out_jac_range_dx == 16'sd0 &&
       out_jac_range_dy == 16'sd0 && out_jac_bearing_dx == 32'sd0 &&
       out_jac_bearing_dy == 32'sd0))
    else $error("coincident beat with nonzero range or Jacobian");
`endif

endmodule
